>>> design/zrd_pkg.sv
// ----------------------------------------------------------------------------
// zrd_pkg: shared types and helpers for the zero-run decompressor
// Parsing phase codes and nibble decoding used by the decoder logic.
// ----------------------------------------------------------------------------
package zrd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned NibW  = 4;
	// A word causes at most sixteen words: two zero parts of up to eight bytes.
	localparam int unsigned CntW  = 5;

	typedef enum logic [1:0] {
		PH_OPCODE = 2'd0,
		PH_DATA1  = 2'd1,
		PH_DATA2  = 2'd2
	} phase_t;

	typedef logic [NibW-1:0] nib_t;
	typedef logic [CntW-1:0] cnt_t;

	// Zero bytes a nibble emits: len+1 when its zero flag is set, else none.
	function automatic cnt_t zero_count(input nib_t nib);
		cnt_t n;
		n = '0;
		if (nib[3]) begin
			n = {2'b00, nib[2:0]} + cnt_t'(1);
		end
		return n;
	endfunction

	// Literal bytes a data nibble announces: 8 - len.
	function automatic nib_t literal_count(input nib_t nib);
		return nib_t'(4'd8 - {1'b0, nib[2:0]});
	endfunction

endpackage

>>> design/zero_run_decompressor.sv
// ----------------------------------------------------------------------------
// zero_run_decompressor: streaming zero-run decoder
// Decodes opcode and literal words of a compressed frame into output words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, data_byte, frame_last) takes one
//   compressed word per cycle while in_ready is high. Output channel
//   (out_valid/out_ready, byte_out, run_last, frame_end) delivers one
//   decompressed word per cycle while the receiver does not stall. Each
//   input word causes zero to sixteen output words: a literal word passes
//   through and may be followed by zero fill, an opcode word may expand to
//   zero fill. The decode state is updated in the cycle the word is
//   accepted; the words it causes are queued in a job register and drained
//   into the output register. An input word is taken every cycle as long
//   as each word causes at most one output word and the receiver does not
//   stall; a word causing more holds the input until the single job
//   register, draining one word per cycle, is down to its last word.
//   A word causing no output never occupies the job register.
//   When the receiver stalls, the output register holds its word and the
//   job register stops draining, which in turn holds off the input.
//   Reset returns the decoder to awaiting an opcode and empties both
//   registers.
// ----------------------------------------------------------------------------
module zero_run_decompressor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [zrd_pkg::ByteW-1:0]   data_byte,
	input  logic                        frame_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [zrd_pkg::ByteW-1:0]   byte_out,
	output logic                        run_last,
	output logic                        frame_end
);
	import zrd_pkg::*;

	// Decode state.
	phase_t phase_q, phase_d;
	nib_t   lit_left_q, lit_left_d;
	nib_t   sec_nib_q, sec_nib_d;

	// Job register: pending words of the current input word.
	logic                job_valid_s1;
	logic                job_lit_s1;
	logic [ByteW-1:0]    job_byte_s1;
	cnt_t                job_cnt_s1;
	logic                job_last_s1;

	// Output register.
	logic                out_valid_q;
	logic [ByteW-1:0]    byte_q;
	logic                run_last_q;
	logic                frame_end_q;

	logic  accept;
	logic  out_load;
	logic  job_done;
	logic  new_lit;
	cnt_t  new_zeros;
	cnt_t  new_total;

	assign out_load = job_valid_s1 && (!out_valid_q || out_ready);
	assign job_done = out_load && (job_cnt_s1 == cnt_t'(1));
	assign in_ready = !job_valid_s1 || job_done;
	assign accept   = in_valid && in_ready;

	// Next decode state and the words this input causes.
	always_comb begin
		nib_t lo;
		nib_t hi;
		logic done;
		lo        = data_byte[NibW-1:0];
		hi        = data_byte[ByteW-1:NibW];
		phase_d   = phase_q;
		lit_left_d = lit_left_q;
		sec_nib_d = sec_nib_q;
		new_lit   = 1'b0;
		new_zeros = '0;
		done      = 1'b0;
		if (phase_q == PH_DATA1 || phase_q == PH_DATA2) begin
			new_lit    = 1'b1;
			done       = (lit_left_q <= nib_t'(1));
			lit_left_d = done ? '0 : lit_left_q - nib_t'(1);
			if (done || frame_last) begin
				lit_left_d = '0;
				phase_d    = PH_OPCODE;
				if (phase_q == PH_DATA1) begin
					if (sec_nib_q[3]) begin
						new_zeros = zero_count(sec_nib_q);
					end else if (!frame_last) begin
						lit_left_d = literal_count(sec_nib_q);
						phase_d    = PH_DATA2;
					end
				end
			end
		end else begin
			if (lo[3] || frame_last) begin
				// The second part starts right away; a data part is dropped
				// when the frame ends here.
				if (hi[3]) begin
					new_zeros = zero_count(lo) + zero_count(hi);
					phase_d   = PH_OPCODE;
				end else if (frame_last) begin
					new_zeros = zero_count(lo);
					phase_d   = PH_OPCODE;
				end else begin
					new_zeros  = zero_count(lo);
					lit_left_d = literal_count(hi);
					phase_d    = PH_DATA2;
				end
			end else begin
				lit_left_d = literal_count(lo);
				sec_nib_d  = hi;
				phase_d    = PH_DATA1;
			end
		end
		if (frame_last) begin
			phase_d    = PH_OPCODE;
			lit_left_d = '0;
		end
	end

	assign new_total = new_zeros + {{(CntW-1){1'b0}}, new_lit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPCODE;
			lit_left_q <= '0;
			sec_nib_q  <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			lit_left_q <= lit_left_d;
			sec_nib_q  <= sec_nib_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (accept) begin
			job_valid_s1 <= (new_total != '0);
		end else if (job_done) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_lit_s1  <= new_lit;
			job_byte_s1 <= data_byte;
			job_cnt_s1  <= new_total;
			job_last_s1 <= frame_last;
		end else if (out_load) begin
			// The literal, if any, always goes out before the zero fill.
			job_lit_s1 <= 1'b0;
			job_cnt_s1 <= job_cnt_s1 - cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			byte_q      <= job_lit_s1 ? job_byte_s1 : '0;
			run_last_q  <= (job_cnt_s1 == cnt_t'(1));
			frame_end_q <= (job_cnt_s1 == cnt_t'(1)) && job_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_out  = byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule
